[rtl/smoothed_zscore_peak_detector_top_macros.svh]
// Assertion macros for the smoothed z-score peak detector checker.
`ifndef SMOOTHED_ZSCORE_PEAK_DETECTOR_TOP_MACROS_SVH
`define SMOOTHED_ZSCORE_PEAK_DETECTOR_TOP_MACROS_SVH

// Clocked check, disabled while reset is asserted.
`define SZPD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked check that also holds during reset.
`define SZPD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[rtl/szpd_pkg.sv]
// Package: widths, constants and command/status types of the peak detector.
`default_nettype none
package szpd_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int FIX_W      = 24;   // Q15.8 filtered values
  localparam int MAX_WINDOW = 64;
  localparam int WL_W       = 7;
  localparam int IDX_W      = $clog2(MAX_WINDOW);
  localparam int THR_W      = 12;
  localparam int INF_W      = 9;
  localparam int SUM_W      = 31;
  localparam int SQS_W      = 54;
  localparam int DIV_NUM_W  = 60;
  localparam int DIV_DEN_W  = 13;
  localparam int DIV_STEPS  = DIV_NUM_W / 2;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
  localparam int VAR_W      = 48;
  localparam int SD_W       = 24;
  localparam int SQRT_STEPS = VAR_W / 2;
  localparam int SQRT_CNT_W = $clog2(SQRT_STEPS);
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INFLUENCE     = 2'd2;

  localparam logic [WL_W-1:0]  WL_RESET  = 7'd30;
  localparam logic [THR_W-1:0] THR_RESET = 12'd896;
  localparam logic [INF_W-1:0] INF_RESET = 9'd128;
  localparam logic [INF_W-1:0] INF_ONE   = 9'd256;

  localparam logic [1:0] SIG_NONE = 2'b00;
  localparam logic [1:0] SIG_POS  = 2'b01;
  localparam logic [1:0] SIG_NEG  = 2'b11;

  typedef struct packed {
    logic accept;   // latch sample, restart series if first
    logic rd;       // ring read, detect operands
    logic det;      // flag decision, blend product
    logic sel;      // pick filtered value, square old entry
    logic wr;       // ring write, running sum
    logic acc;      // square sum, indexes, fill count
    logic prep;     // variance operands
    logic div_go;   // launch dividers
    logic sq_init;  // load square root unit
    logic sq_step;  // one root bit
    logic finish;   // load result register
  } szpd_cmd_t;

  typedef struct packed {
    logic full_after;
    logic div_done;
    logic out_busy;
  } szpd_sts_t;

endpackage
`default_nettype wire

[rtl/szpd_intf.sv]
// Channel interfaces: sample input, result output, configuration write.
`default_nettype none
interface szpd_in_if import szpd_pkg::*;;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       first;
  modport source (output valid, sample, first, input ready);
  modport sink   (input valid, sample, first, output ready);
endinterface

interface szpd_out_if import szpd_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic signed [1:0]       signal;
  logic signed [FIX_W-1:0] win_mean;
  logic [SD_W-1:0]         win_sdev;
  logic                    stats_valid;
  modport source (output valid, signal, win_mean, win_sdev, stats_valid,
                  input ready);
  modport sink   (input valid, signal, win_mean, win_sdev, stats_valid,
                  output ready);
endinterface

interface szpd_cfg_if import szpd_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

[rtl/szpd_div.sv]
// Unsigned restoring divider, two quotient bits per cycle.
`default_nettype none
module szpd_div import szpd_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic [DIV_NUM_W-1:0] num_i,
  input  wire logic [DIV_DEN_W-1:0] den_i,
  output logic                      busy_o,
  output logic [DIV_NUM_W-1:0]      quo_o,
  output logic [DIV_DEN_W-1:0]      rem_o
);
  logic [DIV_NUM_W-1:0] sh_q, sh_d;
  logic [DIV_DEN_W-1:0] rem_q, rem_d, den_q, m1;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 busy_q;
  logic [DIV_DEN_W:0]   r1, r2;
  logic                 ge1, ge2;

  always_comb begin
    r1  = {rem_q, sh_q[DIV_NUM_W-1]};
    ge1 = r1 >= {1'b0, den_q};
    m1  = ge1 ? DIV_DEN_W'(r1 - {1'b0, den_q}) : r1[DIV_DEN_W-1:0];
    r2  = {m1, sh_q[DIV_NUM_W-2]};
    ge2 = r2 >= {1'b0, den_q};
    rem_d = ge2 ? DIV_DEN_W'(r2 - {1'b0, den_q}) : r2[DIV_DEN_W-1:0];
    sh_d  = {sh_q[DIV_NUM_W-3:0], ge1, ge2};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sh_q  <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      sh_q  <= sh_d;
      rem_q <= rem_d;
    end
  end

  assign busy_o = busy_q;
  assign quo_o  = sh_q;
  assign rem_o  = rem_q;
endmodule
`default_nettype wire

[rtl/szpd_dp.sv]
// Datapath: config registers, window ring, running sums, dividers, square root.
`default_nettype none
module szpd_dp import szpd_pkg::*; (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire szpd_cmd_t                  cmd_i,
  output szpd_sts_t                       sts_o,
  input  wire logic signed [SAMPLE_W-1:0] sample_i,
  input  wire logic                       first_i,
  input  wire logic                       cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]       cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0]      cfg_data_i,
  input  wire logic                       out_ready_i,
  output logic                            out_valid_o,
  output logic signed [1:0]               out_signal_o,
  output logic signed [FIX_W-1:0]         out_mean_o,
  output logic [SD_W-1:0]                 out_sd_o,
  output logic                            out_stats_o
);
  function automatic logic [2*FIX_W-1:0] sq_fix(input logic signed [FIX_W-1:0] v);
    logic [FIX_W-1:0] m;
    m = v[FIX_W-1] ? FIX_W'(-v) : FIX_W'(v);
    return m * m;
  endfunction

  // configuration
  logic [WL_W-1:0]  wl_q, len;
  logic [THR_W-1:0] thr_q;
  logic [INF_W-1:0] infl_q, w;
  logic             clr;

  // series state
  logic signed [SUM_W-1:0] sum_q;
  logic [SQS_W-1:0]        sqs_q;
  logic [WL_W-1:0]         fill_q;
  logic [IDX_W-1:0]        widx_q, idx;
  logic signed [FIX_W-1:0] lf_q, lmean_q;
  logic [SD_W-1:0]         lsd_q;

  // per-sample pipeline
  logic signed [FIX_W-1:0] x_q, rdata_q, f_q;
  logic [THR_W+SD_W-1:0]   lim_q;
  logic [FIX_W:0]          adiff_q;
  logic signed [FIX_W:0]   diff;
  logic                    full_q, flag, full_after_q, neg_q;
  logic [1:0]              sig_q;
  logic signed [FIX_W+11:0] blend_q;
  logic [2*FIX_W-1:0]      oldsq_q, fsq_q;
  logic [DIV_NUM_W-1:0]    a_q, b_q, var_num;
  logic [DIV_DEN_W-1:0]    nn_q;
  logic [SUM_W-2:0]        sum_mag;

  logic [FIX_W-1:0] ring_mem [MAX_WINDOW];

  // dividers and root
  logic                 vbusy, mbusy;
  logic [DIV_NUM_W-1:0] vquo, mquo;
  logic [DIV_DEN_W-1:0] vrem, mrem;
  logic [VAR_W-1:0]     rad_q;
  logic [SD_W+1:0]      srem_q, trial;
  logic [SD_W+2:0]      sr;
  logic [SD_W-1:0]      sres_q;
  logic [FIX_W:0]       mean_mag;
  logic signed [FIX_W-1:0] mean_fin;

  logic                    out_valid_q, out_stats_q;
  logic [1:0]              out_sig_q;
  logic signed [FIX_W-1:0] out_mean_q;
  logic [SD_W-1:0]         out_sd_q;

  always_comb begin
    if (wl_q == '0) len = WL_W'(1);
    else if (wl_q > WL_W'(MAX_WINDOW)) len = WL_W'(MAX_WINDOW);
    else len = wl_q;
    w    = (infl_q > INF_ONE) ? INF_ONE : infl_q;
    idx  = ({1'b0, widx_q} >= len) ? '0 : widx_q;
    clr  = (cmd_i.accept && first_i) || (cfg_we_i && cfg_idx_i == CFG_WINDOW_LENGTH);
    diff = FIX_W'(0) + ({x_q[FIX_W-1], x_q} - {lmean_q[FIX_W-1], lmean_q});
    flag = full_q && ({adiff_q, 8'd0} > {3'd0, lim_q});
    sum_mag = sum_q[SUM_W-1] ? (SUM_W-1)'(-sum_q) : sum_q[SUM_W-2:0];
    var_num = (a_q > b_q) ? a_q - b_q : '0;
    sr    = {srem_q[SD_W:0], rad_q[VAR_W-1 -: 2]};
    trial = {sres_q, 2'b01};
    mean_mag = mquo[FIX_W:0] + {{FIX_W{1'b0}}, (neg_q && mrem != '0)};
    mean_fin = neg_q ? FIX_W'(-mean_mag) : mean_mag[FIX_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wl_q   <= WL_RESET;
      thr_q  <= THR_RESET;
      infl_q <= INF_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_WINDOW_LENGTH: wl_q   <= cfg_data_i[WL_W-1:0];
        CFG_THRESHOLD:     thr_q  <= cfg_data_i[THR_W-1:0];
        CFG_INFLUENCE:     infl_q <= cfg_data_i[INF_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      sqs_q   <= '0;
      fill_q  <= '0;
      widx_q  <= '0;
      lf_q    <= '0;
      lmean_q <= '0;
      lsd_q   <= '0;
    end else if (clr) begin
      sum_q   <= '0;
      sqs_q   <= '0;
      fill_q  <= '0;
      widx_q  <= '0;
      lf_q    <= '0;
      lmean_q <= '0;
      lsd_q   <= '0;
    end else begin
      if (cmd_i.rd) widx_q <= idx;
      if (cmd_i.wr)
        sum_q <= sum_q - (full_q ? SUM_W'(rdata_q) : SUM_W'(0)) + SUM_W'(f_q);
      if (cmd_i.acc) begin
        sqs_q  <= sqs_q - (full_q ? SQS_W'(oldsq_q) : SQS_W'(0)) + SQS_W'(fsq_q);
        widx_q <= ({1'b0, widx_q} + 1'b1 >= len) ? '0 : widx_q + 1'b1;
        if (fill_q < len) fill_q <= fill_q + 1'b1;
        lf_q   <= f_q;
      end
      if (cmd_i.finish && full_after_q) begin
        lmean_q <= mean_fin;
        lsd_q   <= sres_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) ring_mem[widx_q] <= f_q;
    if (cmd_i.rd) rdata_q <= ring_mem[idx];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) x_q <= {sample_i, 8'd0};
    if (cmd_i.rd) begin
      lim_q   <= thr_q * lsd_q;
      adiff_q <= diff[FIX_W] ? (FIX_W+1)'(-diff) : diff;
      full_q  <= fill_q >= len;
    end
    if (cmd_i.det) begin
      sig_q   <= flag ? ((x_q > lmean_q) ? SIG_POS : SIG_NEG) : SIG_NONE;
      blend_q <= $signed({1'b0, w}) * x_q + $signed({1'b0, INF_ONE - w}) * lf_q;
    end
    if (cmd_i.sel) begin
      f_q     <= (sig_q != SIG_NONE) ? FIX_W'(blend_q >>> 8) : x_q;
      oldsq_q <= sq_fix(rdata_q);
    end
    if (cmd_i.wr) fsq_q <= sq_fix(f_q);
    if (cmd_i.acc) full_after_q <= (fill_q < len) ? (fill_q + 1'b1 >= len) : 1'b1;
    if (cmd_i.prep) begin
      a_q   <= DIV_NUM_W'(len) * DIV_NUM_W'(sqs_q);
      b_q   <= sum_mag * sum_mag;
      nn_q  <= DIV_DEN_W'(len) * DIV_DEN_W'(len);
      neg_q <= sum_q[SUM_W-1];
    end
    if (cmd_i.sq_init) begin
      rad_q  <= vquo[VAR_W-1:0];
      srem_q <= '0;
      sres_q <= '0;
    end else if (cmd_i.sq_step) begin
      rad_q <= {rad_q[VAR_W-3:0], 2'b00};
      if (sr >= {1'b0, trial}) begin
        srem_q <= (SD_W+2)'(sr - {1'b0, trial});
        sres_q <= {sres_q[SD_W-2:0], 1'b1};
      end else begin
        srem_q <= sr[SD_W+1:0];
        sres_q <= {sres_q[SD_W-2:0], 1'b0};
      end
    end
  end

  szpd_div u_var_div (
    .clk_i, .rst_ni, .start_i(cmd_i.div_go), .num_i(var_num), .den_i(nn_q),
    .busy_o(vbusy), .quo_o(vquo), .rem_o(vrem)
  );

  szpd_div u_mean_div (
    .clk_i, .rst_ni, .start_i(cmd_i.div_go),
    .num_i({{(DIV_NUM_W-SUM_W+1){1'b0}}, sum_mag}),
    .den_i({{(DIV_DEN_W-WL_W){1'b0}}, len}),
    .busy_o(mbusy), .quo_o(mquo), .rem_o(mrem)
  );

  // result register; a new result may load as the old one leaves
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (cmd_i.finish) out_valid_q <= 1'b1;
    else if (out_ready_i) out_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_sig_q   <= sig_q;
      out_stats_q <= full_after_q;
      out_mean_q  <= full_after_q ? mean_fin : '0;
      out_sd_q    <= full_after_q ? sres_q : '0;
    end
  end

  assign sts_o.full_after = full_after_q;
  assign sts_o.div_done   = !(vbusy || mbusy) && (vrem == vrem);
  assign sts_o.out_busy   = out_valid_q && !out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign out_signal_o = out_sig_q;
  assign out_mean_o   = out_mean_q;
  assign out_sd_o     = out_sd_q;
  assign out_stats_o  = out_stats_q;
endmodule
`default_nettype wire

[rtl/szpd_ctrl.sv]
// Controller: sequences one sample through the datapath.
`default_nettype none
module szpd_ctrl import szpd_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire szpd_sts_t sts_i,
  output szpd_cmd_t      cmd_o
);
  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_RD    = 4'd1;
  localparam logic [3:0] ST_DET   = 4'd2;
  localparam logic [3:0] ST_SEL   = 4'd3;
  localparam logic [3:0] ST_WR    = 4'd4;
  localparam logic [3:0] ST_ACC   = 4'd5;
  localparam logic [3:0] ST_PREP  = 4'd6;
  localparam logic [3:0] ST_DIVGO = 4'd7;
  localparam logic [3:0] ST_DIVW  = 4'd8;
  localparam logic [3:0] ST_SQ    = 4'd9;
  localparam logic [3:0] ST_DONE  = 4'd10;

  logic [3:0]            state_q, state_d;
  logic [SQRT_CNT_W-1:0] cnt_q, cnt_d;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.accept = in_valid_i;
        if (in_valid_i) state_d = ST_RD;
      end
      ST_RD:  begin cmd_o.rd  = 1'b1; state_d = ST_DET; end
      ST_DET: begin cmd_o.det = 1'b1; state_d = ST_SEL; end
      ST_SEL: begin cmd_o.sel = 1'b1; state_d = ST_WR;  end
      ST_WR:  begin cmd_o.wr  = 1'b1; state_d = ST_ACC; end
      ST_ACC: begin cmd_o.acc = 1'b1; state_d = ST_PREP; end
      ST_PREP: begin
        cmd_o.prep = 1'b1;
        state_d = sts_i.full_after ? ST_DIVGO : ST_DONE;
      end
      ST_DIVGO: begin cmd_o.div_go = 1'b1; state_d = ST_DIVW; end
      ST_DIVW: begin
        if (sts_i.div_done) begin
          cmd_o.sq_init = 1'b1;
          cnt_d   = '0;
          state_d = ST_SQ;
        end
      end
      ST_SQ: begin
        cmd_o.sq_step = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == SQRT_CNT_W'(SQRT_STEPS - 1)) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!sts_i.out_busy) begin
          cmd_o.finish = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);
endmodule
`default_nettype wire

[rtl/smoothed_zscore_peak_detector_top.sv]
// Top level of the smoothed z-score peak detector.
//
//  channel | dir | beat contents
//  --------+-----+------------------------------------------------------------
//  in_i    | in  | sample (s16), first (restart series)
//  out_o   | out | signal (s2), win_mean (Q15.8), win_sdev, stats_valid
//  cfg_i   | in  | index 0 window_length, 1 threshold, 2 influence; data
//
// Sequence: a warm-up sample runs six update steps, then loads the result
// register and returns to idle.
// Once the window is full a sample runs six update steps, a divider launch,
// a wait on the two radix-4 dividers (mean and variance side by side), a load
// of the root unit, the bit-serial square root, a load of the result register
// and a return to idle.
// Reset restores the register defaults and empties the series; the ring needs
// no clearing since only entries of the current series are read.
// The result register lets the next sample start while a beat waits on out_o;
// a sample stalls in its final cycle only if the previous beat is still held.
// Config beats are always accepted; writing window_length restarts the series.
`default_nettype none
module smoothed_zscore_peak_detector_top import szpd_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  szpd_in_if.sink   in_i,
  szpd_out_if.source out_o,
  szpd_cfg_if.sink  cfg_i
);
  szpd_cmd_t cmd;
  szpd_sts_t sts;
  logic      in_ready;

  // controller owns sequencing; all arithmetic sits in the datapath
  szpd_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  szpd_dp u_dp (
    .clk_i,
    .rst_ni,
    .cmd_i        (cmd),
    .sts_o        (sts),
    .sample_i     (in_i.sample),
    .first_i      (in_i.first),
    .cfg_we_i     (cfg_i.valid),
    .cfg_idx_i    (cfg_i.index),
    .cfg_data_i   (cfg_i.data),
    .out_ready_i  (out_o.ready),
    .out_valid_o  (out_o.valid),
    .out_signal_o (out_o.signal),
    .out_mean_o   (out_o.win_mean),
    .out_sd_o     (out_o.win_sdev),
    .out_stats_o  (out_o.stats_valid)
  );

  assign in_i.ready  = in_ready;
  assign cfg_i.ready = 1'b1;
endmodule
`default_nettype wire

[rtl/szpd_checker.sv]
// Port-level checker for the peak detector, bound to the top level.
`default_nettype none
`include "smoothed_zscore_peak_detector_top_macros.svh"
module szpd_checker import szpd_pkg::*; (
  input wire logic                    clk_i,
  input wire logic                    rst_ni,
  input wire logic                    out_valid_i,
  input wire logic                    out_ready_i,
  input wire logic [1:0]              signal_i,
  input wire logic signed [FIX_W-1:0] mean_i,
  input wire logic [SD_W-1:0]         sd_i,
  input wire logic                    stats_i
);
  `SZPD_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i, "result beat dropped")
  `SZPD_ASSERT(a_sig_code, out_valid_i |-> signal_i != 2'b10, "bad signal code")
  `SZPD_ASSERT(a_warmup_zero, out_valid_i && !stats_i |-> signal_i == SIG_NONE && mean_i == '0 && sd_i == '0, "warm-up beat not zero")
  `SZPD_ASSERT_ALWAYS(a_rst_idle, !rst_ni |=> !out_valid_i, "result during reset")
endmodule

bind smoothed_zscore_peak_detector_top szpd_checker u_szpd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .signal_i    (out_o.signal),
  .mean_i      (out_o.win_mean),
  .sd_i        (out_o.win_sdev),
  .stats_i     (out_o.stats_valid)
);
`default_nettype wire

[dv/tb.sv]
// Self-checking testbench for the smoothed z-score peak detector.
`default_nettype none
module tb;
  import szpd_pkg::*;

  localparam int IDLE_LIMIT = 4000;  // cycles without any beat before giving up
  localparam int SETTLE     = 80;    // worst-case sample latency plus margin

  typedef struct packed {
    logic signed [1:0]       sig;
    logic signed [FIX_W-1:0] mean;
    logic [SD_W-1:0]         sd;
    logic                    valid;
  } peak_result_t;

  // Scoreboard: tracks detector state and holds the expected result beats.
  class peak_scoreboard;
    longint        ring[MAX_WINDOW];
    longint        win_sum;
    longint unsigned sq_sum;
    int unsigned   fill, wr_idx;
    longint        prev_filt, prev_mean, prev_sd;
    int unsigned   win_len_reg, thr_reg, infl_reg;
    peak_result_t  pending_q[$];
    int            failures;

    function new();
      win_len_reg = WL_RESET;
      thr_reg     = THR_RESET;
      infl_reg    = INF_RESET;
      failures    = 0;
      restart();
    endfunction

    function void restart();
      win_sum = 0; sq_sum = 0; fill = 0; wr_idx = 0;
      prev_filt = 0; prev_mean = 0; prev_sd = 0;
    endfunction

    function longint fdiv(longint a, longint b);
      longint q;
      q = a / b;
      if ((a % b) != 0 && a < 0) q--;
      return q;
    endfunction

    function longint unsigned sq(longint v);
      longint unsigned m;
      m = (v < 0) ? longint'(-v) : longint'(v);
      return m * m;
    endfunction

    // Bit-serial floor square root.
    function longint unsigned root(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
      case (idx)
        CFG_WINDOW_LENGTH: begin
          win_len_reg = d[WL_W-1:0];
          restart();
        end
        CFG_THRESHOLD: thr_reg = d[THR_W-1:0];
        CFG_INFLUENCE: infl_reg = d[INF_W-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return pending_q.size();
    endfunction

    // Accepted sample beat: advance the model and queue the expected result.
    function void note_sample(logic signed [SAMPLE_W-1:0] s, logic first);
      peak_result_t r;
      longint x, f, diff, w, old;
      longint unsigned adiff, n, a, b, var_q;
      int unsigned len;
      len = (win_len_reg == 0) ? 1 : (win_len_reg > MAX_WINDOW ? MAX_WINDOW : win_len_reg);
      r = '0;
      if (first) restart();
      x = longint'(s) * 256;
      f = x;
      if (fill >= len) begin
        diff  = x - prev_mean;
        adiff = (diff < 0) ? longint'(-diff) : longint'(diff);
        if ((adiff << 8) > longint'(thr_reg) * prev_sd) begin
          w = (infl_reg > 256) ? 256 : infl_reg;
          r.sig = (x > prev_mean) ? SIG_POS : SIG_NEG;
          f = fdiv(w * x + (256 - w) * prev_filt, 256);
        end
      end
      if (wr_idx >= len) wr_idx = 0;
      if (fill >= len) begin
        old = ring[wr_idx];
        win_sum -= old;
        sq_sum  -= sq(old);
      end
      ring[wr_idx] = f;
      win_sum += f;
      sq_sum  += sq(f);
      wr_idx = (wr_idx + 1 >= len) ? 0 : wr_idx + 1;
      if (fill < len) fill++;
      prev_filt = f;
      if (fill >= len) begin
        n = len;
        a = n * sq_sum;
        b = sq(win_sum);
        var_q = (a > b) ? (a - b) / (n * n) : 0;
        prev_mean = fdiv(win_sum, len);
        prev_sd   = root(var_q);
        r.valid = 1'b1;
        r.mean  = prev_mean[FIX_W-1:0];
        r.sd    = prev_sd[SD_W-1:0];
      end
      pending_q.push_back(r);
    endfunction

    // Accepted result beat: compare against the oldest expectation.
    function void check_result(peak_result_t got);
      peak_result_t exp_r;
      if (pending_q.size() == 0) begin
        failures++;
        if (failures <= 10) $display("unexpected result beat: %p", got);
        return;
      end
      exp_r = pending_q.pop_front();
      if (got !== exp_r) begin
        failures++;
        if (failures <= 10)
          $display("mismatch: sig %0d/%0d mean %0d/%0d sd %0d/%0d valid %0b/%0b (exp/got)",
                   exp_r.sig, got.sig, exp_r.mean, got.mean, exp_r.sd, got.sd,
                   exp_r.valid, got.valid);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #5 clk_i = ~clk_i;

  szpd_in_if  in_if();
  szpd_out_if out_if();
  szpd_cfg_if cfg_if();

  smoothed_zscore_peak_detector_top dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  peak_scoreboard sb = new();
  bit quiet = 1'b0;    // final stretch: no idling on either side
  bit running = 1'b1;  // watchdog armed
  int idle_cycles = 0;

  initial begin
    in_if.valid  = 1'b0;
    in_if.sample = '0;
    in_if.first  = 1'b0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = CFG_WINDOW_LENGTH;
    cfg_if.data  = '0;
  end

  // Beat monitor and watchdog. Values read here are the pre-edge ones.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) sb.note_sample(in_if.sample, in_if.first);
      if (cfg_if.valid && cfg_if.ready) sb.write_reg(cfg_if.index, cfg_if.data);
      if (out_if.valid && out_if.ready)
        sb.check_result({out_if.signal, out_if.win_mean, out_if.win_sdev,
                         out_if.stats_valid});
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (running && idle_cycles >= IDLE_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // Result sink: ready drops in random bursts until the quiet stretch.
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!quiet && $urandom_range(0, 99) < 15) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
    end
  end

  // One sample beat; valid stays high across back-to-back beats.
  task automatic send_sample(logic signed [SAMPLE_W-1:0] s, logic first);
    if (!quiet && $urandom_range(0, 99) < 25) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    in_if.valid  <= 1'b1;
    in_if.sample <= s;
    in_if.first  <= first;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
  endtask

  // Hold off until every expected beat is back and the block has settled.
  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // Register write; only called after drain. Valid drops for a cycle after.
  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= d;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Clean series with random content: level plus noise, occasional spikes.
  task automatic random_series(int count);
    int level, amp, v;
    level = $urandom_range(0, 40000) - 20000;
    amp   = $urandom_range(0, 400);
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 19))
        0, 1:    v = level + ($urandom_range(0, 1) ? 1 : -1) * $urandom_range(2000, 30000);
        2:       v = $signed(16'($urandom()));
        default: v = level + $urandom_range(0, 2 * amp) - amp;
      endcase
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      send_sample(v[SAMPLE_W-1:0], i == 0 || $urandom_range(0, 199) == 0);
    end
  endtask

  initial begin
    int wl;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset settings, then tiny windows with edge values.
    send_sample(16'sh7FFF, 1'b1);
    send_sample(-16'sh8000, 1'b0);
    drain();
    write_cfg(CFG_WINDOW_LENGTH, 12'd2);
    write_cfg(CFG_THRESHOLD, 12'd0);
    write_cfg(CFG_INFLUENCE, 12'd256);
    // Zero deviation: a flat window flags any differing sample.
    send_sample(16'sd0, 1'b1);
    send_sample(16'sd0, 1'b0);
    send_sample(16'sd0, 1'b0);
    send_sample(16'sd5, 1'b0);
    send_sample(-16'sd5, 1'b0);
    send_sample(16'sh7FFF, 1'b0);
    send_sample(-16'sh8000, 1'b0);
    drain();
    // Window length zero acts as one; influence above one saturates.
    write_cfg(CFG_WINDOW_LENGTH, 12'd0);
    write_cfg(CFG_INFLUENCE, 12'h1FF);
    write_cfg(CFG_THRESHOLD, 12'hFFF);
    send_sample(16'sd100, 1'b0);
    send_sample(-16'sd100, 1'b0);
    send_sample(16'sh7FFF, 1'b0);
    drain();
    // Oversized window saturates; upper data bits are dropped.
    write_cfg(CFG_WINDOW_LENGTH, 12'hFFF);
    write_cfg(CFG_INFLUENCE, 12'd0);
    write_cfg(CFG_THRESHOLD, 12'd256);
    for (int i = 0; i < 8; i++)
      send_sample(i[0] ? 16'sh7FFF : -16'sh8000, 1'b0);
    drain();

    // Random phases, each under its own settings.
    for (int ph = 0; ph < 9; ph++) begin
      if (ph == 8) quiet = 1'b1;
      case (ph)
        0: wl = 1;
        1: wl = 64;
        2: wl = 3;
        3: wl = 127;
        default: wl = $urandom_range(2, 12);
      endcase
      write_cfg(CFG_WINDOW_LENGTH, wl[CFG_DATA_W-1:0]);
      write_cfg(CFG_THRESHOLD, (ph == 1) ? 12'hFFF : 12'($urandom_range(0, 1200)));
      write_cfg(CFG_INFLUENCE, (ph == 2) ? 12'h1FF : 12'($urandom_range(0, 300)));
      for (int s = 0; s < 4; s++) random_series($urandom_range(24, 44));
      if (ph != 8) drain();
    end

    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    running = 1'b0;
    if (sb.failures == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end
endmodule
`default_nettype wire
